[rtl/c3sh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c3sh_pkg - shared constants for the 3x3 smoothing / high-pass filter
// Register indexes, configuration widths and filter mode codes.
// ----------------------------------------------------------------------------
package c3sh_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 9;

  localparam logic [CFG_INDEX_W-1:0] REG_FILTER_MODE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COLS_IN_USE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ROWS_IN_USE = 2'd2;

  localparam logic MODE_BLUR     = 1'b0;
  localparam logic MODE_HIGHPASS = 1'b1;

  // smallest grid edge the window can work on
  localparam int MIN_SIZE = 3;

  localparam logic [CFG_DATA_W-1:0] COLS_RESET = 9'd256;
  localparam logic [CFG_DATA_W-1:0] ROWS_RESET = 9'd256;

endpackage

[rtl/c3sh_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c3sh_ram - generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module c3sh_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/c3sh_kernel.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c3sh_kernel - 3x3 weighted sum and result shaping
// Binomial blur (sum / 16, floor) or absolute high-pass (|sum| / 4, saturated).
// ----------------------------------------------------------------------------
module c3sh_kernel
  import c3sh_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           filter_mode,
  // rows: a = two rows up, b = one row up, d = current row; 0 = leftmost
  input  logic signed [SAMPLE_WIDTH-1:0] a0, a1, a2,
  input  logic signed [SAMPLE_WIDTH-1:0] b0, b1, b2,
  input  logic signed [SAMPLE_WIDTH-1:0] d0, d1, d2,
  output logic        [SAMPLE_WIDTH-1:0] result
);

  // 24 * max sample magnitude fits in SAMPLE_WIDTH + 5 bits plus sign
  localparam int AW = SAMPLE_WIDTH + 6;
  localparam logic [SAMPLE_WIDTH-1:0] SAT = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

  logic signed [AW-1:0] edges, corners, centre;
  logic signed [AW-1:0] sum_blur, sum_hp;
  logic        [AW-1:0] mag, quarter;
  logic        [AW-1:0] blur_shift;

  always_comb begin
    centre  = AW'(b1);
    edges   = (AW'(a1) + AW'(b0) + AW'(b2) + AW'(d1)) <<< 1;
    corners = AW'(a0) + AW'(a2) + AW'(d0) + AW'(d2);

    sum_blur   = corners + edges + (centre <<< 2);
    blur_shift = AW'(sum_blur >>> 4);

    sum_hp  = (centre <<< 3) + (centre <<< 2) - edges - corners;
    mag     = sum_hp[AW-1] ? AW'(-sum_hp) : AW'(sum_hp);
    quarter = mag >> 2;

    if (filter_mode == MODE_HIGHPASS) begin
      if (quarter > AW'(SAT)) begin
        result = SAT;
      end else begin
        result = quarter[SAMPLE_WIDTH-1:0];
      end
    end else begin
      result = blur_shift[SAMPLE_WIDTH-1:0];
    end
  end

endmodule

[rtl/conv3x3_smooth_highpass_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv3x3_smooth_highpass_unit - streaming 3x3 filter over a raster height grid
// Line stores in RAM, a 3x3 window, then blur or high-pass per interior cell.
// ----------------------------------------------------------------------------
// Path: an accepted input word is held in stage 1; its result word is taken
//   into the output register, raising m_axis_tvalid, as it leaves stage 1.
// Throughput: one word per cycle unless an interior result waits on
//   m_axis_tready; line stores read at accept, written back one stage later.
// Reset (rst, synchronous): counters to 0, window to 0, mode blur, sizes 256,
//   pipeline empty. Line store RAM contents are not cleared.
// ----------------------------------------------------------------------------
module conv3x3_smooth_highpass_unit
  import c3sh_pkg::*;
#(
  parameter int GRID_SIZE    = 256,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // input word stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,  // [SW-1:0] height_in
  // result word stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     m_axis_tdata,  // [SW-1:0] height_out
  output logic                                  m_axis_tlast,  // frame_last
  // configuration writes
  input  logic                                  cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0]                cfg_index,
  input  logic [CFG_DATA_W-1:0]                 cfg_data
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int DW = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int CW = $clog2(GRID_SIZE);
  // width for size compares: holds GRID_SIZE and the 9-bit register values
  localparam int LW = (CW + 1 > CFG_DATA_W) ? CW + 1 : CFG_DATA_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic                  filter_mode;
  logic [CFG_DATA_W-1:0] cols_cfg;
  logic [CFG_DATA_W-1:0] rows_cfg;

  // --------------------------------------------------------------------------
  // Raster position of the next word; always below GRID_SIZE
  // --------------------------------------------------------------------------
  logic [CW-1:0] col_count;
  logic [CW-1:0] row_count;

  logic [LW-1:0] cols_lim, rows_lim;
  logic [LW-1:0] c_ext, r_ext;
  logic          last_col, last_row, emit_now;

  // sizes outside the legal range are clamped into [3, GRID_SIZE]
  always_comb begin
    if (LW'(cols_cfg) < LW'(MIN_SIZE)) begin
      cols_lim = LW'(MIN_SIZE);
    end else if (LW'(cols_cfg) > LW'(GRID_SIZE)) begin
      cols_lim = LW'(GRID_SIZE);
    end else begin
      cols_lim = LW'(cols_cfg);
    end
    if (LW'(rows_cfg) < LW'(MIN_SIZE)) begin
      rows_lim = LW'(MIN_SIZE);
    end else if (LW'(rows_cfg) > LW'(GRID_SIZE)) begin
      rows_lim = LW'(GRID_SIZE);
    end else begin
      rows_lim = LW'(rows_cfg);
    end

    c_ext    = LW'(col_count);
    r_ext    = LW'(row_count);
    last_col = (c_ext + LW'(1)) >= cols_lim;
    last_row = (r_ext + LW'(1)) >= rows_lim;
    // interior cell whose lower-right neighbour is this word; a counter left
    // past a shrunk limit gives no result
    emit_now = (r_ext >= LW'(2)) && (c_ext >= LW'(2)) &&
               (r_ext < rows_lim) && (c_ext < cols_lim);
  end

  // --------------------------------------------------------------------------
  // Handshake
  //   stage 1 holds the accepted word while the line store read lands;
  //   the output register parts it from the downstream side.
  // --------------------------------------------------------------------------
  logic          s1_valid;
  logic [SW-1:0] s1_x;
  logic [CW-1:0] s1_addr;
  logic          s1_emit;
  logic          s1_last;

  logic          out_free, s1_go, in_fire;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s1_go         = s1_valid && (!s1_emit || out_free);
  assign s_axis_tready = !s1_valid || s1_go;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // --------------------------------------------------------------------------
  // Line stores: upper holds row r-2, middle row r-1. Read at accept, written
  // back at the same column when the word leaves stage 1. Consecutive words
  // always address different columns, so no bypass is needed.
  // --------------------------------------------------------------------------
  logic [SW-1:0] top_rd, mid_rd;

  c3sh_ram #(
    .WIDTH (SW),
    .DEPTH (GRID_SIZE)
  ) u_line_upper (
    .clk     (clk),
    .wr_en   (s1_go),
    .wr_addr (s1_addr),
    .wr_data (mid_rd),
    .rd_en   (in_fire),
    .rd_addr (col_count),
    .rd_data (top_rd)
  );

  c3sh_ram #(
    .WIDTH (SW),
    .DEPTH (GRID_SIZE)
  ) u_line_middle (
    .clk     (clk),
    .wr_en   (s1_go),
    .wr_addr (s1_addr),
    .wr_data (s1_x),
    .rd_en   (in_fire),
    .rd_addr (col_count),
    .rd_data (mid_rd)
  );

  // --------------------------------------------------------------------------
  // Window: columns c-1 (w0..w2) and c-2 (w3..w5) of rows r-2, r-1, r
  // --------------------------------------------------------------------------
  logic [SW-1:0] w0, w1, w2, w3, w4, w5;
  logic [SW-1:0] kern_result;

  c3sh_kernel #(
    .SAMPLE_WIDTH (SW)
  ) u_kernel (
    .filter_mode (filter_mode),
    .a0          (w3),
    .a1          (w0),
    .a2          (top_rd),
    .b0          (w4),
    .b1          (w1),
    .b2          (mid_rd),
    .d0          (w5),
    .d1          (w2),
    .d2          (s1_x),
    .result      (kern_result)
  );

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  logic [SW-1:0] out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode   <= MODE_BLUR;
      cols_cfg      <= COLS_RESET;
      rows_cfg      <= ROWS_RESET;
      col_count     <= '0;
      row_count     <= '0;
      s1_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
      w0            <= '0;
      w1            <= '0;
      w2            <= '0;
      w3            <= '0;
      w4            <= '0;
      w5            <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_FILTER_MODE: filter_mode <= cfg_data[0];
          REG_COLS_IN_USE: cols_cfg    <= cfg_data;
          REG_ROWS_IN_USE: rows_cfg    <= cfg_data;
          default:         ;
        endcase
      end

      // raster counters advance per accepted word
      if (in_fire) begin
        if (last_col) begin
          col_count <= '0;
          row_count <= last_row ? '0 : row_count + CW'(1);
        end else begin
          col_count <= col_count + CW'(1);
        end
      end

      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end

      // window shifts one column as the word leaves stage 1
      if (s1_go) begin
        w3 <= w0;
        w4 <= w1;
        w5 <= w2;
        w0 <= top_rd;
        w1 <= mid_rd;
        w2 <= s1_x;
      end

      if (s1_go && s1_emit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_x    <= s_axis_tdata[SW-1:0];
      s1_addr <= col_count;
      s1_emit <= emit_now;
      s1_last <= last_col && last_row;
    end
    if (s1_go && s1_emit) begin
      out_data     <= kern_result;
      m_axis_tlast <= s1_last;
    end
  end

  assign m_axis_tdata = DW'(out_data);

endmodule
